// File: rtl/core/kdpt_pkg.sv
// ----------------------------------------------------------------------------
// kdpt_pkg
// shared widths, defaults and the lane result type for the key press timer
// ----------------------------------------------------------------------------
package kdpt_pkg;

    // fixed field widths of the scan and result requests
    localparam int KEY_LEVELS_W = 4;
    localparam int NOW_W        = 32;
    localparam int KEY_IDX_W    = 2;
    localparam int DUR_W        = 32;

    // parameter defaults
    localparam int NUM_KEYS_DEF   = 4;
    localparam int TIME_WIDTH_DEF = 32;

    // what one lane reports for the current scan
    typedef struct packed {
        logic             hit;
        logic [DUR_W-1:0] dur;
    } t_lane_res;

endpackage

// File: rtl/core/kdpt_if.sv
// ----------------------------------------------------------------------------
// kdpt_if
// valid/ready channels for key scans and for press duration results
// ----------------------------------------------------------------------------
interface kdpt_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [kdpt_pkg::KEY_LEVELS_W-1:0]    key_levels;
    logic [kdpt_pkg::NOW_W-1:0]           now_ticks;

    modport source (output valid, output key_levels, output now_ticks, input ready);
    modport sink   (input valid, input key_levels, input now_ticks, output ready);
endinterface

interface kdpt_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [kdpt_pkg::KEY_IDX_W-1:0]       key_index;
    logic [kdpt_pkg::DUR_W-1:0]           press_duration;
    logic                                 last;

    modport source (output valid, output key_index, output press_duration, output last,
                    input ready);
    modport sink   (input valid, input key_index, input press_duration, input last,
                    output ready);
endinterface

// File: rtl/core/kdpt_lane.sv
// ----------------------------------------------------------------------------
// kdpt_lane
// debounce machine and press timestamp for a single key
// ----------------------------------------------------------------------------
module kdpt_lane #(
    parameter int TIME_WIDTH = kdpt_pkg::TIME_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_level,
    input  logic [TIME_WIDTH-1:0] i_now,
    output kdpt_pkg::t_lane_res   o_res
);
    import kdpt_pkg::*;

    typedef enum logic [1:0] {
        PH_UP,
        PH_FALLING,
        PH_DOWN,
        PH_RISING
    } t_phase;

    t_phase                r_phase;
    t_phase                n_phase;
    logic [TIME_WIDTH-1:0] r_press_time;
    logic [TIME_WIDTH-1:0] w_elapsed;

    assign w_elapsed = i_now - r_press_time;

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_UP:      n_phase = i_level ? PH_UP : PH_FALLING;
            PH_FALLING: n_phase = i_level ? PH_UP : PH_DOWN;
            PH_DOWN:    n_phase = i_level ? PH_RISING : PH_DOWN;
            PH_RISING:  n_phase = i_level ? PH_UP : PH_DOWN;
            default:    n_phase = PH_UP;
        endcase
    end

    // confirmed release with a nonzero elapsed time
    assign o_res.hit = (r_phase == PH_RISING) && i_level && (w_elapsed != '0);
    assign o_res.dur = DUR_W'(w_elapsed);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_UP;
        end else if (i_accept) begin
            r_phase <= n_phase;
            if (r_phase == PH_FALLING && !i_level) begin
                r_press_time <= i_now;
            end
        end
    end

endmodule

// File: rtl/core/kdpt_merge.sv
// ----------------------------------------------------------------------------
// kdpt_merge
// collects a scan's lane hits, one out per cycle while ready, lowest key first
// ----------------------------------------------------------------------------
module kdpt_merge #(
    parameter int NUM_KEYS = kdpt_pkg::NUM_KEYS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  kdpt_pkg::t_lane_res i_lane_res [NUM_KEYS],
    output logic                o_in_ready,
    kdpt_out_if.source          o_res
);
    import kdpt_pkg::*;

    localparam int SEL_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    // stage: hits of the last accepted scan
    logic [NUM_KEYS-1:0] r_smask;
    logic [DUR_W-1:0]    r_sdur [NUM_KEYS];
    // work: scan being serialised
    logic [NUM_KEYS-1:0] r_wmask;
    logic [DUR_W-1:0]    r_wdur [NUM_KEYS];
    // output register
    logic                r_ov;
    logic [KEY_IDX_W-1:0] r_key_index;
    logic [DUR_W-1:0]    r_dur;
    logic                r_last;

    logic [NUM_KEYS-1:0] w_hits;
    logic [NUM_KEYS-1:0] w_rest;
    logic [SEL_W-1:0]    w_sel;
    logic                w_emit;
    logic                w_work_free;
    logic                w_s2w;

    always_comb begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            w_hits[k] = i_lane_res[k].hit;
        end
    end

    // lowest pending key
    always_comb begin
        w_sel = '0;
        for (int k = NUM_KEYS - 1; k >= 0; k--) begin
            if (r_wmask[k]) begin
                w_sel = SEL_W'(k);
            end
        end
    end

    assign w_rest      = r_wmask & (r_wmask - 1'b1);
    assign w_emit      = (|r_wmask) && (!r_ov || o_res.ready);
    assign w_work_free = !(|r_wmask) || (w_emit && (w_rest == '0));
    assign w_s2w       = (|r_smask) && w_work_free;
    assign o_in_ready  = !(|r_smask) || w_s2w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smask <= '0;
            r_wmask <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_accept) begin
                r_smask <= w_hits;
                for (int k = 0; k < NUM_KEYS; k++) begin
                    r_sdur[k] <= i_lane_res[k].dur;
                end
            end else if (w_s2w) begin
                r_smask <= '0;
            end

            if (w_s2w) begin
                r_wmask <= r_smask;
                r_wdur  <= r_sdur;
            end else if (w_emit) begin
                r_wmask <= w_rest;
            end

            if (w_emit) begin
                r_ov        <= 1'b1;
                r_key_index <= KEY_IDX_W'(w_sel);
                r_dur       <= r_wdur[w_sel];
                r_last      <= (w_rest == '0);
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_res.valid          = r_ov;
    assign o_res.key_index      = r_key_index;
    assign o_res.press_duration = r_dur;
    assign o_res.last           = r_last;

endmodule

// File: rtl/core/key_debounce_press_timer.sv
// ----------------------------------------------------------------------------
// key_debounce_press_timer
// two-sample key debounce with press duration measurement for a bank of keys
// ----------------------------------------------------------------------------
//  channel  | dir | payload                               | meaning
//  ---------+-----+---------------------------------------+-------------------------
//  i_scan   | in  | key_levels[3:0], now_ticks[31:0]       | one scan of all keys
//  o_res    | out | key_index[1:0], press_duration[31:0], | one request per reported
//           |     | last                                  | release
//
//  a scan is taken every cycle while the merger keeps up; a scan that reports
//  n releases gives n result requests, one per cycle while the output is ready
//  the first result of a scan passes through the stage, work and output registers
//  reset (synchronous, active low) puts every key in the up phase and empties
//  the stage, work and output registers; press times are not cleared
//  a stalled output holds its result; one more reporting scan waits in the stage
// ----------------------------------------------------------------------------
module key_debounce_press_timer #(
    parameter int NUM_KEYS   = kdpt_pkg::NUM_KEYS_DEF,
    parameter int TIME_WIDTH = kdpt_pkg::TIME_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kdpt_in_if.sink    i_scan,
    kdpt_out_if.source o_res
);
    import kdpt_pkg::*;

    logic                  w_accept;
    logic                  w_in_ready;
    logic [TIME_WIDTH-1:0] w_now;
    logic [NUM_KEYS-1:0]   w_level;
    t_lane_res             w_lane_res [NUM_KEYS];

    assign i_scan.ready = w_in_ready;
    assign w_accept     = i_scan.valid && w_in_ready;

    // only the low TIME_WIDTH bits of the tick count take part
    assign w_now = TIME_WIDTH'(i_scan.now_ticks);

    // one lane per key; keys beyond the level field read as pressed
    for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
        if (g < KEY_LEVELS_W) begin : g_lvl
            assign w_level[g] = i_scan.key_levels[g];
        end else begin : g_nolvl
            assign w_level[g] = 1'b0;
        end

        kdpt_lane #(
            .TIME_WIDTH (TIME_WIDTH)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_accept (w_accept),
            .i_level  (w_level[g]),
            .i_now    (w_now),
            .o_res    (w_lane_res[g])
        );
    end

    // combine lane hits into an ordered stream of result requests
    kdpt_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_lane_res (w_lane_res),
        .o_in_ready (w_in_ready),
        .o_res      (o_res)
    );

`ifndef SYNTHESIS
    // input back-pressure only while the merger has a result on its way out
    a_stall_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_scan.ready |=> o_res.valid)
        else $error("scan stalled with no result pending");

    // results of one scan leave back to back
    a_run_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && !o_res.last) |=> o_res.valid)
        else $error("gap inside a run of results");
`endif

endmodule

// File: tb/kdpt_release_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdpt_release_monitor
// watches the scan and result channels, debounces each accepted scan on its
// own copy of the key state and compares every result request in order
// ----------------------------------------------------------------------------
module kdpt_release_monitor (
    input  logic i_clk,
    input  logic i_rst_n,
    kdpt_in_if   i_scan,
    kdpt_out_if  i_res,
    output int   o_mismatches,
    output int   o_outstanding,
    output int   o_releases
);
    import kdpt_pkg::*;

    typedef enum logic [1:0] {
        KEY_UP,
        KEY_FALLING,
        KEY_HELD,
        KEY_RISING
    } t_key_phase;

    typedef struct packed {
        logic [KEY_IDX_W-1:0] key;
        logic [DUR_W-1:0]     dur;
        logic                 last;
    } t_release;

    t_key_phase       phase_q    [NUM_KEYS_DEF];
    logic [DUR_W-1:0] pressed_at [NUM_KEYS_DEF];
    t_release         due_q      [$];
    int               mismatches = 0;
    int               releases   = 0;
    int               n_due      = 0;

    assign o_mismatches  = mismatches;
    assign o_outstanding = n_due;
    assign o_releases    = releases;

    task automatic report(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // one scan through every key machine, results in ascending key order
    task automatic debounce_scan(input logic [KEY_LEVELS_W-1:0] lv,
                                 input logic [NOW_W-1:0] now);
        t_release         batch [$];
        t_release         r;
        logic [DUR_W-1:0] held;
        for (int k = 0; k < NUM_KEYS_DEF; k++) begin
            case (phase_q[k])
                KEY_UP: begin
                    if (!lv[k]) phase_q[k] = KEY_FALLING;
                end
                KEY_FALLING: begin
                    if (!lv[k]) begin
                        phase_q[k]    = KEY_HELD;
                        pressed_at[k] = now;
                    end else begin
                        phase_q[k] = KEY_UP;
                    end
                end
                KEY_HELD: begin
                    if (lv[k]) phase_q[k] = KEY_RISING;
                end
                default: begin
                    if (lv[k]) begin
                        held       = now - pressed_at[k];
                        phase_q[k] = KEY_UP;
                        if (held != 0) begin
                            r.key  = KEY_IDX_W'(k);
                            r.dur  = held;
                            r.last = 1'b0;
                            batch.push_back(r);
                        end
                    end else begin
                        phase_q[k] = KEY_HELD;
                    end
                end
            endcase
        end
        if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
        foreach (batch[j]) due_q.push_back(batch[j]);
    endtask

    task automatic check_release(input logic [KEY_IDX_W-1:0] key,
                                 input logic [DUR_W-1:0] dur, input logic last);
        t_release want;
        if (due_q.size() == 0) begin
            report($sformatf("unexpected result key %0d duration %0d", key, dur));
        end else begin
            want = due_q.pop_front();
            releases++;
            if (key !== want.key)
                report($sformatf("key index %0d, wanted %0d", key, want.key));
            if (dur !== want.dur)
                report($sformatf("key %0d duration %0d, wanted %0d", want.key, dur, want.dur));
            if (last !== want.last)
                report($sformatf("key %0d last %b, wanted %b", want.key, last, want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_KEYS_DEF; k++) phase_q[k] = KEY_UP;
            due_q.delete();
        end else begin
            if (i_res.valid && i_res.ready)
                check_release(i_res.key_index, i_res.press_duration, i_res.last);
            if (i_scan.valid && i_scan.ready)
                debounce_scan(i_scan.key_levels, i_scan.now_ticks);
        end
        n_due = due_q.size();
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// key press timer bench: directed press and release cases, then random key
// activity with gaps, a long output hold-off and a drain pause
// ----------------------------------------------------------------------------
module tb_top;
    import kdpt_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 120;

    logic i_clk = 1'b0;
    logic i_rst_n;

    kdpt_in_if  scan_if ();
    kdpt_out_if res_if ();

    int mismatches;
    int outstanding;
    int releases;
    int scans_sent   = 0;
    int cycles       = 0;
    int holds_served = 0;
    int hold_ticket;
    bit calm;

    // random key activity: each key keeps its level for a run of scans
    logic [KEY_LEVELS_W-1:0] lvl_now;
    int                      run_left [NUM_KEYS_DEF];
    logic [NOW_W-1:0]        tick;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    key_debounce_press_timer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_scan  (scan_if),
        .o_res   (res_if)
    );

    kdpt_release_monitor u_release_mon (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_scan        (scan_if),
        .i_res         (res_if),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_releases    (releases)
    );

    // mostly back to back, now and then a short gap, rarely a long gap
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one scan request and hold it until the block takes it
    task automatic send_scan(input logic [KEY_LEVELS_W-1:0] lv, input logic [NOW_W-1:0] now);
        int gap;
        gap = pick_gap(calm);
        if (gap > 0) begin
            scan_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        scan_if.valid      = 1'b1;
        scan_if.key_levels = lv;
        scan_if.now_ticks  = now;
        @(posedge i_clk);
        while (!scan_if.ready) @(posedge i_clk);
        scans_sent++;
        @(negedge i_clk);
    endtask

    // next random scan: runs of two or more samples get presses confirmed,
    // runs of one give glitches; ticks mostly creep forward, sometimes stand
    // still, jump anywhere or sit just below the wrap
    task automatic send_random(input bit noise);
        int                      r;
        logic [KEY_LEVELS_W-1:0] lv;
        for (int k = 0; k < NUM_KEYS_DEF; k++) begin
            if (run_left[k] == 0) begin
                lvl_now[k] = ~lvl_now[k];
                r = $urandom_range(0, 99);
                if (r < 10)      run_left[k] = 1;
                else if (r < 92) run_left[k] = $urandom_range(2, 6);
                else             run_left[k] = $urandom_range(8, 25);
            end
            run_left[k]--;
        end
        lv = noise ? KEY_LEVELS_W'($urandom_range(0, 15)) : lvl_now;
        r = $urandom_range(0, 99);
        if (r < 8)       tick = tick;
        else if (r < 78) tick = tick + $urandom_range(1, 60);
        else if (r < 90) tick = $urandom();
        else             tick = 32'hFFFF_FFFF - $urandom_range(0, 40);
        send_scan(lv, tick);
    endtask

    task automatic wait_drained();
        while (outstanding != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // result side: random stalls, plus one long hold-off when asked for
    initial begin
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            int stall_left;
            @(negedge i_clk);
            if (hold_ticket != holds_served) begin
                holds_served++;
                res_if.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (stall_left > 0) begin
                res_if.ready = 1'b0;
                stall_left--;
            end else begin
                res_if.ready = 1'b1;
                stall_left   = pick_gap(calm);
            end
        end
    end

    // watchdog on the whole run
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        i_rst_n            = 1'b0;
        scan_if.valid      = 1'b0;
        scan_if.key_levels = '1;
        scan_if.now_ticks  = '0;
        calm               = 1'b0;
        hold_ticket        = 0;
        lvl_now            = '1;
        tick               = '0;
        for (int k = 0; k < NUM_KEYS_DEF; k++) run_left[k] = 3;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // key 0 pressed and released on one tick: zero duration, no request
        send_scan(4'b1110, 32'd100);
        send_scan(4'b1110, 32'd100);
        send_scan(4'b1111, 32'd100);
        send_scan(4'b1111, 32'd100);
        // glitch on key 1 while falling
        send_scan(4'b1101, 32'd200);
        send_scan(4'b1111, 32'd201);
        // all keys down, a glitch on key 0 while rising, then all released
        // past the wrap so every key reports in one scan
        send_scan(4'b0000, 32'd300);
        send_scan(4'b0000, 32'd310);
        send_scan(4'b0001, 32'd320);
        send_scan(4'b0000, 32'd321);
        send_scan(4'b1111, 32'd400);
        send_scan(4'b1111, 32'd5);
        // longest duration on key 2
        send_scan(4'b1011, 32'd7);
        send_scan(4'b1011, 32'd1);
        send_scan(4'b1111, 32'd9);
        send_scan(4'b1111, 32'd0);
        // shortest duration on key 3
        send_scan(4'b0111, 32'd50);
        send_scan(4'b0111, 32'd50);
        send_scan(4'b1111, 32'd51);
        send_scan(4'b1111, 32'd51);
        send_scan(4'b1111, 32'hFFFF_FFFF);

        // random activity with gaps on both sides
        repeat (40) send_random(1'b0);

        // long hold-off on the result side while scans keep coming
        hold_ticket <= hold_ticket + 1;
        calm        <= 1'b1;
        repeat (30) send_random(1'b0);

        // sender waits for every outstanding release
        scan_if.valid = 1'b0;
        wait_drained();

        // back to back on both sides
        repeat (40) send_random(1'b0);
        calm <= 1'b0;

        // gaps again, with some fully random key patterns mixed in
        repeat (40) send_random($urandom_range(0, 3) == 0);
        scan_if.valid = 1'b0;

        while (outstanding != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("run: %0d key scans sent, %0d release requests checked, %0d mismatches",
                 scans_sent, releases, mismatches);
        $display("run: covered glitches, zero and extreme durations, tick wrap, hold-off");
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/kdpt_pkg.sv
rtl/core/kdpt_if.sv
rtl/core/kdpt_lane.sv
rtl/core/kdpt_merge.sv
rtl/core/key_debounce_press_timer.sv
tb/kdpt_release_monitor.sv
tb/tb_top.sv
